// ===== hw/rtl/double_ended_queue_defines.svh =====
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

   // Number of ring slots and the widths that follow from it.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int VALUE_W = 32;

   // Request codes.
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_LIST       = 3'd4;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]                req_type;
      logic signed [VALUE_W-1:0] value;
   } deq_req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic [1:0]                status;
      logic                      last;
   } deq_rsp_word_type;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue: push and pop words return their status word in the cycle after
// acceptance; a new push or pop may be accepted every cycle while no listing runs and
// the output is not stalled. A listing reads each stored element from the ring memory,
// then loads it into the output, and holds the request side until the last one is sent.
// Reset (synchronous, active high) empties the queue and the output register at once;
// the slot memory itself is not cleared, as only occupied slots are ever read.
`include "double_ended_queue_defines.svh"

module double_ended_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  deq_pkg::deq_req_word_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output deq_pkg::deq_rsp_word_type rsp_data
);

   // Sequencer states. The listing alternates between a read of the ring memory and
   // the transfer of the read data into the output register.
   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_READ = 3'b010,
      SEQ_SEND = 3'b100
   } deq_seq_type;

   // The ring store: one synchronous memory with a registered read port.
   logic [deq_pkg::VALUE_W-1:0] slots_mem [deq_pkg::DEPTH];
   logic [deq_pkg::VALUE_W-1:0] rd_data_ff;

   deq_seq_type                 seq_ff, seq_in;
   logic [deq_pkg::ADDR_W-1:0]  front_ff, front_in;
   logic [deq_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic [deq_pkg::ADDR_W-1:0]  list_idx_ff, list_idx_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   deq_pkg::deq_rsp_word_type   rsp_ff, rsp_in;

   logic                        req_accept;
   logic                        out_free;
   logic                        is_full;
   logic                        is_empty;
   logic                        list_last;
   logic                        wr_en;
   logic [deq_pkg::ADDR_W-1:0]  wr_addr;
   logic [deq_pkg::ADDR_W-1:0]  rd_addr;

   // Adds an offset to a ring position. Both operands stay below DEPTH, so the sum
   // stays below twice DEPTH and one conditional subtraction wraps it.
   function automatic logic [deq_pkg::ADDR_W-1:0] ring_add(
      input logic [deq_pkg::ADDR_W-1:0] base,
      input logic [deq_pkg::CNT_W-1:0]  offset
   );
      logic [deq_pkg::CNT_W:0] sum;
      sum = (deq_pkg::CNT_W + 1)'(base) + (deq_pkg::CNT_W + 1)'(offset);
      if (sum >= (deq_pkg::CNT_W + 1)'(deq_pkg::DEPTH)) begin
         sum = sum - (deq_pkg::CNT_W + 1)'(deq_pkg::DEPTH);
      end
      return sum[deq_pkg::ADDR_W-1:0];
   endfunction

   // The output register can take a new word when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (seq_ff != SEQ_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign is_full   = (fill_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign is_empty  = (fill_ff == '0);
   assign list_last = ((deq_pkg::CNT_W'(list_idx_ff) + 1'b1) == fill_ff);
   assign rd_addr   = ring_add(front_ff, deq_pkg::CNT_W'(list_idx_ff));

   always_comb begin
      seq_in       = seq_ff;
      front_in     = front_ff;
      fill_in      = fill_ff;
      list_idx_in  = list_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (seq_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               // Every recognised request yields a status word with last set; the
               // listing of a non-empty queue replaces it by the element words.
               rsp_in.element = '0;
               rsp_in.status  = deq_pkg::STATUS_OK;
               rsp_in.last    = 1'b1;
               case (req_data.req_type)
                  deq_pkg::REQ_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = deq_pkg::STATUS_FULL;
                     end else begin
                        front_in = (front_ff == '0) ?
                                   deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) :
                                   front_ff - 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        fill_in  = fill_ff + 1'b1;
                     end
                  end
                  deq_pkg::REQ_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_add(front_ff, fill_ff);
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  deq_pkg::REQ_POP_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        front_in = ring_add(front_ff, deq_pkg::CNT_W'(1));
                        fill_in  = fill_ff - 1'b1;
                     end
                  end
                  deq_pkg::REQ_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  deq_pkg::REQ_LIST: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        list_idx_in = '0;
                        seq_in      = SEQ_READ;
                     end
                  end
                  default: begin
                     // Unknown request codes are taken and dropped without a word.
                  end
               endcase
            end
         end
         SEQ_READ: begin
            // The memory read is issued at this edge; the data is there next cycle.
            seq_in = SEQ_SEND;
         end
         SEQ_SEND: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.element = rd_data_ff;
               rsp_in.status  = deq_pkg::STATUS_OK;
               rsp_in.last    = list_last;
               if (list_last) begin
                  seq_in = SEQ_IDLE;
               end else begin
                  list_idx_in = list_idx_ff + 1'b1;
                  seq_in      = SEQ_READ;
               end
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // Ring memory: one write port for pushes, one registered read port for listing.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_mem[wr_addr] <= req_data.value;
      end
      if (seq_ff == SEQ_READ) begin
         rd_data_ff <= slots_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         front_ff     <= '0;
         fill_ff      <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The fill count never passes the ring depth.
   `DEQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "fill count above depth")
   // No request word is taken while a listing is running.
   `DEQ_ASSERT_NOW(a_list_blocks, seq_ff != SEQ_IDLE, req_stall, "request accepted during listing")
   // A listed element that finds the output free is presented in the next cycle.
   `DEQ_ASSERT_NEXT(a_list_emit, seq_ff == SEQ_SEND && out_free, rsp_valid_ff && rsp_ff.status == deq_pkg::STATUS_OK, "listed element not presented")
   // A pop that finds the queue occupied removes exactly one element.
   `DEQ_ASSERT_NEXT(a_pop_count, req_accept && !is_empty && (req_data.req_type == deq_pkg::REQ_POP_FRONT || req_data.req_type == deq_pkg::REQ_POP_BACK), fill_ff == $past(fill_ff) - 1'b1, "pop did not remove one element")

endmodule

// ===== sim/deq_response_check.sv =====
`timescale 1ns / 100ps

module deq_response_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  deq_pkg::deq_req_word_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  deq_pkg::deq_rsp_word_type rsp_data,
   output int                        failures,
   output int                        pending,
   output int                        results_checked
);

   // Shadow copy of the ring store and its pointers.
   logic signed [deq_pkg::VALUE_W-1:0] shadow_slots [deq_pkg::DEPTH];
   logic [deq_pkg::ADDR_W-1:0]         shadow_front;
   logic [deq_pkg::CNT_W-1:0]          shadow_fill;

   deq_pkg::deq_rsp_word_type due_rsp_words [$];
   int                        fail_tally;
   int                        checked_tally;

   initial begin
      fail_tally    = 0;
      checked_tally = 0;
   end

   function automatic deq_pkg::deq_rsp_word_type make_rsp(
      logic signed [deq_pkg::VALUE_W-1:0] element, logic [1:0] status, logic last);
      deq_pkg::deq_rsp_word_type word;
      word.element = element;
      word.status  = status;
      word.last    = last;
      return word;
   endfunction

   function automatic int ring_slot(int offset);
      return (int'(shadow_front) + offset) % deq_pkg::DEPTH;
   endfunction

   // Appends one word to the tail of the list of words still to come.
   task automatic add_due(input deq_pkg::deq_rsp_word_type word);
      due_rsp_words = {due_rsp_words, word};
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_tally++;
   endtask

   // Works out the response words that one accepted request word causes.
   task automatic predict_responses(input deq_pkg::deq_req_word_type word);
      int fill;
      fill = int'(shadow_fill);
      case (word.req_type)
         deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
            if (fill >= deq_pkg::DEPTH) begin
               add_due(make_rsp('0, deq_pkg::STATUS_FULL, 1'b1));
            end else begin
               if (word.req_type == deq_pkg::REQ_PUSH_FRONT) begin
                  shadow_front = deq_pkg::ADDR_W'(ring_slot(deq_pkg::DEPTH - 1));
                  shadow_slots[int'(shadow_front)] = word.value;
               end else begin
                  shadow_slots[ring_slot(fill)] = word.value;
               end
               shadow_fill = shadow_fill + 1'b1;
               add_due(make_rsp('0, deq_pkg::STATUS_OK, 1'b1));
            end
         end
         deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
            if (fill == 0) begin
               add_due(make_rsp('0, deq_pkg::STATUS_EMPTY, 1'b1));
            end else begin
               if (word.req_type == deq_pkg::REQ_POP_FRONT) begin
                  shadow_front = deq_pkg::ADDR_W'(ring_slot(1));
               end
               shadow_fill = shadow_fill - 1'b1;
               add_due(make_rsp('0, deq_pkg::STATUS_OK, 1'b1));
            end
         end
         deq_pkg::REQ_LIST: begin
            if (fill == 0) begin
               add_due(make_rsp('0, deq_pkg::STATUS_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < fill; i++) begin
                  add_due(make_rsp(shadow_slots[ring_slot(i)], deq_pkg::STATUS_OK,
                                   i == fill - 1));
               end
            end
         end
         default: begin
            // Unused request codes are ignored by the queue.
         end
      endcase
   endtask

   task automatic check_response(input deq_pkg::deq_rsp_word_type got);
      deq_pkg::deq_rsp_word_type want;
      checked_tally++;
      if (due_rsp_words.size() == 0) begin
         report_mismatch($sformatf("response word %h with none expected", got));
      end else begin
         want = due_rsp_words[0];
         due_rsp_words.delete(0);
         if (got.element !== want.element)
            report_mismatch($sformatf("element %0d, expected %0d", got.element,
                                      want.element));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_front = '0;
         shadow_fill  = '0;
         due_rsp_words.delete();
      end else begin
         if (req_valid && !req_stall) predict_responses(req_data);
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
      end
      failures        <= fail_tally;
      pending         <= due_rsp_words.size();
      results_checked <= checked_tally;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Run length and safety limits. A listing of a full queue gives DEPTH words, each of
   // which may sit behind a stall burst, so the limit is set far above any plausible
   // correct run.
   localparam int ITEMS_TOTAL  = 450;
   localparam int QUIET_AFTER  = 390;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 2 * deq_pkg::DEPTH + 16;
   localparam int REQ_CODES    = 8;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   deq_pkg::deq_req_word_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   deq_pkg::deq_rsp_word_type rsp_data;

   int failures;
   int pending;
   int results_checked;

   // Stimulus bookkeeping. The occupancy estimate lets the stimulus steer the queue
   // towards full and towards empty; it plays no part in checking.
   int  level        = 0;
   int  words_sent   = 0;
   int  ignored_sent = 0;
   int  full_pushes  = 0;
   int  empty_pops   = 0;
   int  listings     = 0;
   int  cycle_count  = 0;
   bit  quiet        = 1'b0;

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   deq_response_check response_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The watchdog counts clock cycles and gives up once the limit is reached.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d response words outstanding.",
               cycle_count, pending);
      $display("FAILURE");
      $finish;
   end

   // The receiving side mixes free-running stretches with stall bursts, both of random
   // length. Once the run has gone quiet it never stalls again.
   initial begin
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Values lean towards the extremes and the all-zero and all-one patterns, since those
   // are where sign handling and storage faults are most likely to show.
   function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(deq_pkg::VALUE_W-1){1'b0}}};
         1:       return {1'b0, {(deq_pkg::VALUE_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Offers one request word and holds it until the queue accepts it. Valid stays high
   // between back-to-back words; an idle gap follows some of them until the run goes quiet.
   task automatic send_word(input logic [2:0] kind,
                            input logic signed [deq_pkg::VALUE_W-1:0] val);
      req_data.req_type <= kind;
      req_data.value    <= val;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      case (kind)
         deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
            if (level >= deq_pkg::DEPTH) full_pushes++;
            else level++;
         end
         deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
            if (level == 0) empty_pops++;
            else level--;
         end
         deq_pkg::REQ_LIST: listings++;
         default: ignored_sent++;
      endcase
      if (kind <= deq_pkg::REQ_LIST) words_sent++;
      if (words_sent >= QUIET_AFTER) quiet = 1'b1;

      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_push();
      send_word($urandom_range(0, 1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT,
                pick_value());
   endtask

   task automatic send_pop();
      send_word($urandom_range(0, 1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT,
                pick_value());
   endtask

   initial begin
      int r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: pops and a listing on an empty queue, pushes of the extreme
      // values at both ends, every unused request code, and a wind-down back to empty.
      send_word(deq_pkg::REQ_POP_FRONT, pick_value());
      send_word(deq_pkg::REQ_POP_BACK, pick_value());
      send_word(deq_pkg::REQ_LIST, '1);
      send_word(deq_pkg::REQ_PUSH_FRONT, {1'b1, {(deq_pkg::VALUE_W-1){1'b0}}});
      send_word(deq_pkg::REQ_PUSH_BACK, {1'b0, {(deq_pkg::VALUE_W-1){1'b1}}});
      send_word(deq_pkg::REQ_PUSH_FRONT, '0);
      send_word(deq_pkg::REQ_PUSH_BACK, '1);
      send_word(deq_pkg::REQ_LIST, '0);
      for (int k = int'(deq_pkg::REQ_LIST) + 1; k < REQ_CODES; k++)
         send_word(3'(k), pick_value());
      send_word(deq_pkg::REQ_POP_FRONT, '0);
      send_word(deq_pkg::REQ_LIST, '0);
      send_word(deq_pkg::REQ_POP_BACK, '1);
      send_word(deq_pkg::REQ_LIST, '0);
      send_word(deq_pkg::REQ_POP_BACK, '0);
      send_word(deq_pkg::REQ_POP_FRONT, '0);
      send_word(deq_pkg::REQ_POP_FRONT, '0);
      send_word(deq_pkg::REQ_LIST, '0);
      send_word(deq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
      send_word(deq_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA);
      send_word(deq_pkg::REQ_LIST, '0);
      send_word(deq_pkg::REQ_POP_FRONT, '0);
      send_word(deq_pkg::REQ_POP_BACK, '0);

      // Random rounds. A fill round drives the queue to full, pushes into it while full
      // and then lists all DEPTH words; a drain round empties it and pops past empty;
      // a mixed round makes an even spread of pushes and pops, with some listings and noise words.
      while (words_sent < ITEMS_TOTAL) begin
         case ($urandom_range(0, 2))
            0: begin
               while (level < deq_pkg::DEPTH) begin
                  if ($urandom_range(0, 11) == 0) send_word(deq_pkg::REQ_LIST, pick_value());
                  else send_push();
               end
               repeat ($urandom_range(1, 3)) send_push();
               send_word(deq_pkg::REQ_LIST, pick_value());
            end
            1: begin
               while (level > 0) begin
                  if ($urandom_range(0, 11) == 0) send_word(deq_pkg::REQ_LIST, pick_value());
                  else send_pop();
               end
               repeat ($urandom_range(1, 2)) send_pop();
               send_word(deq_pkg::REQ_LIST, pick_value());
            end
            default: begin
               repeat ($urandom_range(20, 40)) begin
                  r = $urandom_range(0, 19);
                  if (r < 8) send_push();
                  else if (r < 16) send_pop();
                  else if (r < 18) send_word(deq_pkg::REQ_LIST, pick_value());
                  else send_word(
                     3'($urandom_range(int'(deq_pkg::REQ_LIST) + 1, REQ_CODES - 1)),
                     pick_value());
               end
            end
         endcase
      end
      req_valid <= 1'b0;

      // Waiting for the clock lets the checker take in the last accepted word before the pending
      // count is trusted; then every response word must arrive, and the quiet spell
      // afterwards gives any stray word the chance to show itself.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d request words (%0d listings, %0d ignored codes), %0d response",
               words_sent + ignored_sent, listings, ignored_sent, results_checked);
      $display("words checked; %0d pushes into a full queue, %0d pops from an empty one.",
               full_pushes, empty_pops);
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/double_ended_queue.sv
sim/deq_response_check.sv
sim/testbench.sv
